// ===== sv/pgg_pkg.sv =====
// Shared types, constants and step functions of the polar Gaussian generator.
package pgg_pkg;

  localparam int UNIFORM_BITS = 24;
  localparam int IN_FIELD_W   = 24;
  localparam int SQ_W         = 2 * UNIFORM_BITS;
  localparam int LOG_CELLS    = 32;
  localparam int SQRT_CELLS   = 32;
  localparam int DIV_CELLS    = 33;

  localparam logic [UNIFORM_BITS:0] U_FULL = {1'b1, {UNIFORM_BITS{1'b0}}};
  localparam logic [60:0] TWO_LN2_Q60 = 61'h162E42FEFA39EF35;
  localparam logic [31:0] MEAN_RESET = 32'h0000_0000;
  localparam logic [30:0] STD_RESET  = 31'd65536;

  typedef enum logic [0:0] {
    CFG_MEAN = 1'b0,
    CFG_STD  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [UNIFORM_BITS-1:0] a_a;
    logic [UNIFORM_BITS-1:0] a_b;
    logic                    neg_a;
    logic                    neg_b;
    logic [5:0]              p;
    logic [4:0]              j;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] dop;
    logic [63:0] m;
    logic [31:0] frac;
  } log_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] h_rem;
    logic [63:0] h_res;
    logic [63:0] d_rem;
    logic [63:0] d_res;
  } sqrt_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] d;
    logic [64:0] rem_a;
    logic [32:0] q_a;
    logic [64:0] rem_b;
    logic [32:0] q_b;
  } div_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sq_pair_t;

  typedef struct packed {
    logic [64:0] rem;
    logic [32:0] q;
  } div_pair_t;

  typedef struct packed {
    logic                    bad;
    logic                    neg;
    logic [UNIFORM_BITS-1:0] mag;
  } umap_t;

  function automatic umap_t uni_map(input logic [UNIFORM_BITS-1:0] u);
    logic [UNIFORM_BITS:0] twice;
    logic [UNIFORM_BITS:0] diff;
    umap_t r;
    twice = {u, 1'b0};
    if (u[UNIFORM_BITS-1]) begin
      diff = twice - U_FULL;
    end else begin
      diff = U_FULL - twice;
    end
    r.bad = diff[UNIFORM_BITS];
    r.neg = ~u[UNIFORM_BITS-1];
    r.mag = diff[UNIFORM_BITS-1:0];
    return r;
  endfunction

  function automatic logic [5:0] top_bit(input logic [63:0] s);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (s[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic sq_pair_t sqrt_step(input logic [63:0] rem, input logic [63:0] res,
                                         input logic [63:0] bitv);
    logic [64:0] trial;
    sq_pair_t r;
    trial = {1'b0, res} + {1'b0, bitv};
    if ({1'b0, rem} >= trial) begin
      r.rem = rem - trial[63:0];
      r.res = (res >> 1) + bitv;
    end else begin
      r.rem = rem;
      r.res = res >> 1;
    end
    return r;
  endfunction

  function automatic div_pair_t div_step(input logic [64:0] rem, input logic [32:0] q,
                                         input logic [64:0] dd);
    div_pair_t r;
    if (rem >= dd) begin
      r.rem = rem - dd;
      r.q   = {q[31:0], 1'b1};
    end else begin
      r.rem = rem;
      r.q   = {q[31:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== sv/pgg_log_cell.sv =====
// One bit of the log2 fraction: square the mantissa over two stages and renormalise.
module pgg_log_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  pgg_pkg::log_t  in_p,
  output logic           out_v,
  output pgg_pkg::log_t  out_p
);

  logic                 a_v_r;
  logic [63:0]          pp_ll_r;
  logic [62:0]          pp_lh_r;
  logic [61:0]          pp_hh_r;
  pgg_pkg::side_t       side_r;
  logic [63:0]          dop_r;
  logic [31:0]          frac_r;

  logic [63:0]          pp_ll_nxt;
  logic [62:0]          pp_lh_nxt;
  logic [61:0]          pp_hh_nxt;
  logic [31:0]          ml;
  logic [30:0]          mh;

  logic                 b_v_r;
  pgg_pkg::log_t        out_p_r;
  pgg_pkg::log_t        out_p_nxt;
  logic [126:0]         sq_full;
  logic [63:0]          sq;

  always_comb begin
    ml        = in_p.m[31:0];
    mh        = in_p.m[62:32];
    pp_ll_nxt = {32'b0, ml} * {32'b0, ml};
    pp_lh_nxt = 63'(ml) * 63'(mh);
    pp_hh_nxt = 62'(mh) * 62'(mh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hh_r <= pp_hh_nxt;
      side_r  <= in_p.side;
      dop_r   <= in_p.dop;
      frac_r  <= in_p.frac;
      out_p_r <= out_p_nxt;
    end
  end

  always_comb begin
    sq_full = {1'b0, pp_hh_r, 64'b0} + {31'b0, pp_lh_r, 33'b0} + {63'b0, pp_ll_r};
    sq      = sq_full[125:62];
    out_p_nxt.side = side_r;
    out_p_nxt.dop  = dop_r;
    if (sq[63]) begin
      out_p_nxt.m    = {1'b0, sq[63:1]};
      out_p_nxt.frac = {frac_r[30:0], 1'b1};
    end else begin
      out_p_nxt.m    = sq;
      out_p_nxt.frac = {frac_r[30:0], 1'b0};
    end
  end

  assign out_v = b_v_r;
  assign out_p = out_p_r;

endmodule

// ===== sv/pgg_sqrt_cell.sv =====
// One digit of the two integer square roots, sqrt(-2 ln w) and the divisor.
module pgg_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [4:0]      step,
  input  logic            in_v,
  input  pgg_pkg::sqrt_t  in_p,
  output logic            out_v,
  output pgg_pkg::sqrt_t  out_p
);

  logic                 v_r;
  pgg_pkg::sqrt_t       p_r;
  pgg_pkg::sqrt_t       p_nxt;
  logic [63:0]          bitv;
  pgg_pkg::sq_pair_t    hs;
  pgg_pkg::sq_pair_t    ds;

  always_comb begin
    bitv        = 64'd1 << (6'd62 - {step, 1'b0});
    hs          = pgg_pkg::sqrt_step(in_p.h_rem, in_p.h_res, bitv);
    ds          = pgg_pkg::sqrt_step(in_p.d_rem, in_p.d_res, bitv);
    p_nxt.side  = in_p.side;
    p_nxt.h_rem = hs.rem;
    p_nxt.h_res = hs.res;
    p_nxt.d_rem = ds.rem;
    p_nxt.d_res = ds.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign out_v = v_r;
  assign out_p = p_r;

endmodule

// ===== sv/pgg_div_cell.sv =====
// One quotient bit of both restoring divisions by the shared divisor.
module pgg_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [5:0]     shift_k,
  input  logic           in_v,
  input  pgg_pkg::div_t  in_p,
  output logic           out_v,
  output pgg_pkg::div_t  out_p
);

  logic                 v_r;
  pgg_pkg::div_t        p_r;
  pgg_pkg::div_t        p_nxt;
  logic [64:0]          dd;
  pgg_pkg::div_pair_t   da;
  pgg_pkg::div_pair_t   db;

  always_comb begin
    dd          = {33'b0, in_p.d} << shift_k;
    da          = pgg_pkg::div_step(in_p.rem_a, in_p.q_a, dd);
    db          = pgg_pkg::div_step(in_p.rem_b, in_p.q_b, dd);
    p_nxt.side  = in_p.side;
    p_nxt.d     = in_p.d;
    p_nxt.rem_a = da.rem;
    p_nxt.q_a   = da.q;
    p_nxt.rem_b = db.rem;
    p_nxt.q_b   = db.q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign out_v = v_r;
  assign out_p = p_r;

endmodule

// ===== sv/polar_gaussian_generator_unit.sv =====
// Polar-method Gaussian generator: front end, cell chains, scaling and output register.
//
// One uniform pair is accepted per clock while in_tready is high. A rejected pair
// leaves no trace; an accepted pair appears as two results on consecutive output
// transactions, the second with tlast high. The pipeline is a chain of 64 log
// stages, 32 square-root cells and 33 divider cells that all advance together;
// since each kept pair needs two output transactions, the single output register
// sets the sustained rate at one result per cycle while out_tready is high, and
// in_tready stays low for as long as a finished pair meets an output register
// that cannot take it. in_tready is low during reset.
module polar_gaussian_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // uniform_a [23:0], uniform_b [47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // normal_value [31:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int U  = pgg_pkg::UNIFORM_BITS;
  localparam int SW = pgg_pkg::SQ_W;

  logic [31:0] mean_r;
  logic [30:0] std_r;

  logic adv;
  logic tail_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= pgg_pkg::MEAN_RESET;
      std_r  <= pgg_pkg::STD_RESET;
    end else if (cfg_we) begin
      case (pgg_pkg::cfg_idx_t'(cfg_addr))
        pgg_pkg::CFG_MEAN: mean_r <= cfg_wdata;
        pgg_pkg::CFG_STD:  std_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // front end
  pgg_pkg::umap_t  ma;
  pgg_pkg::umap_t  mb;
  logic            s0_v_r;
  pgg_pkg::side_t  s0_side_r;
  pgg_pkg::side_t  s0_side_nxt;

  always_comb begin
    ma = pgg_pkg::uni_map(in_tdata[U-1:0]);
    mb = pgg_pkg::uni_map(in_tdata[pgg_pkg::IN_FIELD_W +: U]);
    s0_side_nxt       = '0;
    s0_side_nxt.a_a   = ma.mag;
    s0_side_nxt.a_b   = mb.mag;
    s0_side_nxt.neg_a = ma.neg;
    s0_side_nxt.neg_b = mb.neg;
  end

  logic            s1_v_r;
  pgg_pkg::side_t  s1_side_r;
  logic [SW-1:0]   s1_sqa_r;
  logic [SW-1:0]   s1_sqb_r;

  logic [SW:0]     s2_sum;
  logic            s2_bad;
  logic            s2_v_r;
  pgg_pkg::side_t  s2_side_r;
  logic [SW-1:0]   s2_s_r;

  logic [63:0]     s3_s64;
  logic [5:0]      s3_p;
  logic [5:0]      s3_pj;
  logic [4:0]      s3_j;
  pgg_pkg::log_t   log0_nxt;
  pgg_pkg::log_t   log0_p_r;
  logic            log0_v_r;

  always_comb begin
    s2_sum = {1'b0, s1_sqa_r} + {1'b0, s1_sqb_r};
    s2_bad = s2_sum[SW] || (s2_sum == '0);
    s3_s64 = 64'(s2_s_r);
    s3_p   = pgg_pkg::top_bit(s3_s64);
    s3_pj  = 6'd63 - s3_p;
    s3_j   = s3_pj[5:1];
    log0_nxt.side   = s2_side_r;
    log0_nxt.side.p = s3_p;
    log0_nxt.side.j = s3_j;
    log0_nxt.dop    = s3_s64 << {s3_j, 1'b0};
    log0_nxt.frac   = '0;
    if (s3_p <= 6'd62) begin
      log0_nxt.m = s3_s64 << (6'd62 - s3_p);
    end else begin
      log0_nxt.m = s3_s64 >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      log0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r   <= in_tvalid && !ma.bad && !mb.bad;
      s1_v_r   <= s0_v_r;
      s2_v_r   <= s1_v_r && !s2_bad;
      log0_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= s0_side_nxt;
      s1_side_r <= s0_side_r;
      s1_sqa_r  <= SW'(s0_side_r.a_a) * SW'(s0_side_r.a_a);
      s1_sqb_r  <= SW'(s0_side_r.a_b) * SW'(s0_side_r.a_b);
      s2_side_r <= s1_side_r;
      s2_s_r    <= s2_sum[SW-1:0];
      log0_p_r  <= log0_nxt;
    end
  end

  // log2 chain
  pgg_pkg::log_t log_p [0:pgg_pkg::LOG_CELLS];
  logic          log_v [0:pgg_pkg::LOG_CELLS];

  assign log_p[0] = log0_p_r;
  assign log_v[0] = log0_v_r;

  for (genvar gi = 0; gi < pgg_pkg::LOG_CELLS; gi++) begin : g_log
    pgg_log_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .in_v  (log_v[gi]),
      .in_p  (log_p[gi]),
      .out_v (log_v[gi+1]),
      .out_p (log_p[gi+1])
    );
  end

  // -2 ln w
  logic            t1_v_r;
  pgg_pkg::side_t  t1_side_r;
  logic [63:0]     t1_dop_r;
  logic [38:0]     t1_nl_r;

  logic            t2_v_r;
  pgg_pkg::side_t  t2_side_r;
  logic [63:0]     t2_dop_r;
  logic [63:0]     t2_pp0_r;
  logic [60:0]     t2_pp1_r;
  logic [38:0]     t2_pp2_r;
  logic [35:0]     t2_pp3_r;

  logic [38:0]     nl_nxt;
  logic [100:0]    t3_sum;
  pgg_pkg::sqrt_t  sq0_nxt;
  pgg_pkg::sqrt_t  sq0_p_r;
  logic            sq0_v_r;

  always_comb begin
    nl_nxt = {7'(SW) - {1'b0, log_p[pgg_pkg::LOG_CELLS].side.p}, 32'b0}
           - {7'b0, log_p[pgg_pkg::LOG_CELLS].frac};
    t3_sum = {37'b0, t2_pp0_r} + {8'b0, t2_pp1_r, 32'b0} + {30'b0, t2_pp2_r, 32'b0}
           + {1'b0, t2_pp3_r, 64'b0};
    sq0_nxt.side  = t2_side_r;
    sq0_nxt.h_rem = {t3_sum[99:60], 24'b0};
    sq0_nxt.h_res = '0;
    sq0_nxt.d_rem = t2_dop_r;
    sq0_nxt.d_res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r  <= 1'b0;
      t2_v_r  <= 1'b0;
      sq0_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r  <= log_v[pgg_pkg::LOG_CELLS];
      t2_v_r  <= t1_v_r;
      sq0_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_side_r <= log_p[pgg_pkg::LOG_CELLS].side;
      t1_dop_r  <= log_p[pgg_pkg::LOG_CELLS].dop;
      t1_nl_r   <= nl_nxt;
      t2_side_r <= t1_side_r;
      t2_dop_r  <= t1_dop_r;
      t2_pp0_r  <= {32'b0, t1_nl_r[31:0]} * {32'b0, pgg_pkg::TWO_LN2_Q60[31:0]};
      t2_pp1_r  <= 61'(t1_nl_r[31:0]) * 61'(pgg_pkg::TWO_LN2_Q60[60:32]);
      t2_pp2_r  <= 39'(t1_nl_r[38:32]) * 39'(pgg_pkg::TWO_LN2_Q60[31:0]);
      t2_pp3_r  <= 36'(t1_nl_r[38:32]) * 36'(pgg_pkg::TWO_LN2_Q60[60:32]);
      sq0_p_r   <= sq0_nxt;
    end
  end

  // square-root chain
  pgg_pkg::sqrt_t sq_p [0:pgg_pkg::SQRT_CELLS];
  logic           sq_v [0:pgg_pkg::SQRT_CELLS];

  assign sq_p[0] = sq0_p_r;
  assign sq_v[0] = sq0_v_r;

  for (genvar gi = 0; gi < pgg_pkg::SQRT_CELLS; gi++) begin : g_sqrt
    pgg_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .step  (5'(gi)),
      .in_v  (sq_v[gi]),
      .in_p  (sq_p[gi]),
      .out_v (sq_v[gi+1]),
      .out_p (sq_p[gi+1])
    );
  end

  // numerators
  pgg_pkg::sqrt_t  sq_last;
  logic [63:0]     sh_a;
  logic [63:0]     sh_b;
  logic [31:0]     h_val;

  logic            y1_v_r;
  pgg_pkg::side_t  y1_side_r;
  logic [63:0]     y1_na_r;
  logic [63:0]     y1_nb_r;
  logic [31:0]     y1_d_r;

  pgg_pkg::div_t   dv0_nxt;
  pgg_pkg::div_t   dv0_p_r;
  logic            dv0_v_r;

  always_comb begin
    sq_last = sq_p[pgg_pkg::SQRT_CELLS];
    h_val   = sq_last.h_res[31:0];
    sh_a    = 64'(sq_last.side.a_a) << sq_last.side.j;
    sh_b    = 64'(sq_last.side.a_b) << sq_last.side.j;
    dv0_nxt.side  = y1_side_r;
    dv0_nxt.d     = y1_d_r;
    dv0_nxt.rem_a = {1'b0, y1_na_r} + {34'b0, y1_d_r[31:1]};
    dv0_nxt.q_a   = '0;
    dv0_nxt.rem_b = {1'b0, y1_nb_r} + {34'b0, y1_d_r[31:1]};
    dv0_nxt.q_b   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_v_r  <= 1'b0;
      dv0_v_r <= 1'b0;
    end else if (adv) begin
      y1_v_r  <= sq_v[pgg_pkg::SQRT_CELLS];
      dv0_v_r <= y1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_side_r <= sq_last.side;
      y1_na_r   <= {32'b0, sh_a[31:0]} * {32'b0, h_val};
      y1_nb_r   <= {32'b0, sh_b[31:0]} * {32'b0, h_val};
      y1_d_r    <= sq_last.d_res[31:0];
      dv0_p_r   <= dv0_nxt;
    end
  end

  // divider chain
  pgg_pkg::div_t dv_p [0:pgg_pkg::DIV_CELLS];
  logic          dv_v [0:pgg_pkg::DIV_CELLS];

  assign dv_p[0] = dv0_p_r;
  assign dv_v[0] = dv0_v_r;

  for (genvar gi = 0; gi < pgg_pkg::DIV_CELLS; gi++) begin : g_div
    pgg_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .shift_k (6'(pgg_pkg::DIV_CELLS - 1 - gi)),
      .in_v    (dv_v[gi]),
      .in_p    (dv_p[gi]),
      .out_v   (dv_v[gi+1]),
      .out_p   (dv_p[gi+1])
    );
  end

  // scaling, rounding and saturation
  function automatic logic [31:0] finish(input logic [63:0] prod, input logic neg,
                                         input logic [31:0] mean);
    logic [64:0]        rnd;
    logic signed [38:0] mag;
    logic signed [38:0] sv;
    logic signed [38:0] tot;
    logic [31:0]        r;
    rnd = {1'b0, prod} + 65'(1 << 27);
    mag = {2'b0, rnd[64:28]};
    sv  = neg ? -mag : mag;
    tot = sv + {{7{mean[31]}}, mean};
    if (tot > 39'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (tot < -39'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = tot[31:0];
    end
    return r;
  endfunction

  logic            f1_v_r;
  logic            f1_neg_a_r;
  logic            f1_neg_b_r;
  logic [63:0]     f1_pa_r;
  logic [63:0]     f1_pb_r;

  logic            f2_v_r;
  logic [31:0]     f2_a_r;
  logic [31:0]     f2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= dv_v[pgg_pkg::DIV_CELLS];
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_neg_a_r <= dv_p[pgg_pkg::DIV_CELLS].side.neg_a;
      f1_neg_b_r <= dv_p[pgg_pkg::DIV_CELLS].side.neg_b;
      f1_pa_r    <= {31'b0, dv_p[pgg_pkg::DIV_CELLS].q_a} * {33'b0, std_r};
      f1_pb_r    <= {31'b0, dv_p[pgg_pkg::DIV_CELLS].q_b} * {33'b0, std_r};
      f2_a_r     <= finish(f1_pa_r, f1_neg_a_r, mean_r);
      f2_b_r     <= finish(f1_pb_r, f1_neg_b_r, mean_r);
    end
  end

  // output register: hold a pair, send it as two transactions
  logic        tail_v_r;
  logic        tail_idx_r;
  logic [31:0] tail_a_r;
  logic [31:0] tail_b_r;

  assign tail_free = !tail_v_r || (tail_idx_r && out_tready);
  assign adv       = !f2_v_r || tail_free;
  assign in_tready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_v_r   <= 1'b0;
      tail_idx_r <= 1'b0;
    end else if (adv && f2_v_r) begin
      tail_v_r   <= 1'b1;
      tail_idx_r <= 1'b0;
    end else if (tail_v_r && out_tready) begin
      if (tail_idx_r) begin
        tail_v_r <= 1'b0;
      end else begin
        tail_idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f2_v_r) begin
      tail_a_r <= f2_a_r;
      tail_b_r <= f2_b_r;
    end
  end

  assign out_tvalid = tail_v_r;
  assign out_tdata  = tail_idx_r ? tail_b_r : tail_a_r;
  assign out_tlast  = tail_idx_r;

endmodule

// ===== verif/tb_polar_gaussian_generator_unit.sv =====
// Self-checking testbench for the polar Gaussian generator: directed table, random pairs, stalls.
`timescale 1ns / 1ps

module tb_polar_gaussian_generator_unit;

  localparam int          IDLE_LIMIT = 20000;
  localparam int          SETTLE     = 200;
  localparam logic [63:0] LN2X2_Q60  = 64'h162E42FEFA39EF35;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_REJECT, ROW_ZERO_A, ROW_ZERO_B} row_kind_t;

  typedef struct {
    logic [23:0] ua;
    logic [23:0] ub;
    row_kind_t   kind;
  } row_t;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } variate_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // uniform_a [23:0], uniform_b [47:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // normal_value [31:0]
  logic        out_tlast;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  variate_t    variate_q[$];
  logic [31:0] mean_r;
  logic [30:0] std_r;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          rx_hold_len;
  int          errors;
  int          pairs_sent;
  int          pairs_kept;
  int          variates_seen;
  int          idle_cycles;
  bit          watchdog_on;

  polar_gaussian_generator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mul_hi(input logic [63:0] x, input logic [63:0] y,
                                         input int sh);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    prod = prod >> sh;
    return prod[63:0];
  endfunction

  function automatic logic [31:0] scale_variate(input logic [63:0] y, input bit neg);
    logic [63:0] mag;
    longint      v;
    mag = (y * {33'd0, std_r} + (64'd1 << 27)) >> 28;
    v   = neg ? -longint'(mag) : longint'(mag);
    v   = v + longint'(signed'(mean_r));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Return 1 and both variates for a kept pair, 0 for a rejected one.
  function automatic bit gauss_pair(input logic [23:0] ua, input logic [23:0] ub,
                                    output logic [31:0] ra, output logic [31:0] rb);
    logic [63:0] aa, ab, s, m, frac, nl, t, h, d, ya, yb;
    bit          neg_a, neg_b;
    int          p, j;
    ra = 32'd0;
    rb = 32'd0;
    if (ua == 0 || ub == 0) return 1'b0;
    neg_a = !ua[23];
    neg_b = !ub[23];
    aa = neg_a ? 64'd8388608 * 2 - 2 * ua : 2 * ua - 64'd16777216;
    ab = neg_b ? 64'd8388608 * 2 - 2 * ub : 2 * ub - 64'd16777216;
    s  = aa * aa + ab * ab;
    if ((s >> 48) != 0 || s == 0) return 1'b0;
    p = 0;
    for (int k = 63; k > 0; k--) begin
      if (s[k]) begin
        p = k;
        break;
      end
    end
    m    = s << (62 - p);
    frac = 64'd0;
    for (int k = 0; k < 32; k++) begin
      m    = mul_hi(m, m, 62);
      frac = frac << 1;
      if (m[63]) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    nl = (64'(48 - p) << 32) - frac;
    t  = mul_hi(nl, LN2X2_Q60, 60);
    h  = isqrt(t << 24);
    j  = (63 - p) / 2;
    d  = isqrt(s << (2 * j));
    ya = ((aa << j) * h + d / 2) / d;
    yb = ((ab << j) * h + d / 2) / d;
    ra = scale_variate(ya, neg_a);
    rb = scale_variate(yb, neg_b);
    return 1'b1;
  endfunction

  task automatic cfg_write(input pgg_pkg::cfg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pgg_pkg::CFG_MEAN) mean_r = v;
    else std_r = v[30:0];
  endtask

  task automatic send_pair(input logic [23:0] ua, input logic [23:0] ub,
                           input row_kind_t kind);
    logic [31:0] ra, rb;
    bit          kept;
    @(negedge clk);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ub, ua};
    do @(posedge clk); while (!in_tready);
    kept = gauss_pair(ua, ub, ra, rb);
    pairs_sent++;
    if (kind == ROW_ZERO_A) ra = mean_r;
    if (kind == ROW_ZERO_B) rb = mean_r;
    if (kind != ROW_REJECT && kept) begin
      pairs_kept++;
      variate_q.push_back('{ra, 1'b0});
      variate_q.push_back('{rb, 1'b1});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (variate_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    logic [23:0] ua, ub;
    for (int i = 0; i < n; i++) begin
      ua = 24'($urandom);
      ub = 24'($urandom);
      if ($urandom_range(9) == 0) ua = ($urandom_range(1)) ? 24'hFFFFFF : 24'h000001;
      if ($urandom_range(9) == 0) ub = 24'(24'h800000 + $urandom_range(3) - 1);
      send_pair(ua, ub, ROW_PREDICT);
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold_len > 0) begin
      out_tready  <= 1'b0;
      rx_hold_len <= rx_hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    variate_t exp_v;
    if (out_tvalid && out_tready) begin
      variates_seen++;
      if (variate_q.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        exp_v = variate_q.pop_front();
        if (out_tdata !== exp_v.value) begin
          $display("%0t: normal_value mismatch: expected %h, actual %h",
                   $time, exp_v.value, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_v.last) begin
          $display("%0t: last_of_pair mismatch: expected %b, actual %b",
                   $time, exp_v.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !watchdog_on) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  row_t rows[] = '{
    '{24'h000000, 24'h400000, ROW_REJECT},
    '{24'h400000, 24'h000000, ROW_REJECT},
    '{24'h800000, 24'h800000, ROW_REJECT},
    '{24'hFFFFFF, 24'hFFFFFF, ROW_REJECT},
    '{24'h000001, 24'h000001, ROW_REJECT},
    '{24'h800000, 24'h400000, ROW_ZERO_A},
    '{24'hC00000, 24'h800000, ROW_ZERO_B},
    '{24'h800001, 24'h800000, ROW_ZERO_B},
    '{24'h800000, 24'h7FFFFF, ROW_ZERO_A},
    '{24'h800001, 24'h7FFFFF, ROW_PREDICT},
    '{24'hFFFFFF, 24'h800000, ROW_ZERO_B},
    '{24'h000001, 24'h800000, ROW_ZERO_B},
    '{24'hFFFFFF, 24'h800001, ROW_PREDICT},
    '{24'h000001, 24'hFFFFFF, ROW_REJECT},
    '{24'hA00000, 24'h600000, ROW_PREDICT},
    '{24'h5A5A5A, 24'hA5A5A5, ROW_PREDICT},
    '{24'hDA8279, 24'h800000, ROW_ZERO_B},
    '{24'h2A0000, 24'hD60000, ROW_PREDICT}
  };

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = pgg_pkg::CFG_MEAN;
    cfg_wdata    = '0;
    mean_r       = pgg_pkg::MEAN_RESET;
    std_r        = pgg_pkg::STD_RESET;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_len  = 0;
    errors       = 0;
    pairs_sent   = 0;
    pairs_kept   = 0;
    variates_seen = 0;
    idle_cycles  = 0;
    watchdog_on  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n       <= 1'b1;
    watchdog_on = 1'b1;

    foreach (rows[i]) send_pair(rows[i].ua, rows[i].ub, rows[i].kind);
    drain();

    run_random(40);
    drain();

    cfg_write(pgg_pkg::CFG_MEAN, 32'h7FFF_FFFF);
    cfg_write(pgg_pkg::CFG_STD, 32'h7FFF_FFFF);
    tx_idle_pct = 45;
    run_random(60);
    drain();

    cfg_write(pgg_pkg::CFG_MEAN, 32'h8000_0000);
    cfg_write(pgg_pkg::CFG_STD, 32'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 45;
    run_random(60);
    drain();

    cfg_write(pgg_pkg::CFG_MEAN, $urandom);
    cfg_write(pgg_pkg::CFG_STD, $urandom_range(32'h0004_0000, 32'h0000_0100));
    tx_idle_pct  = 29;
    rx_stall_pct = 29;
    run_random(60);
    drain();

    // hold the output back while pairs keep coming, so the pipeline backs up
    cfg_write(pgg_pkg::CFG_MEAN, 32'hFFFF_0000);
    cfg_write(pgg_pkg::CFG_STD, 32'h0002_0000);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_len  = 400;
    run_random(180);
    drain();

    $display("Covered %0d pairs (%0d kept, %0d variates) under five register settings,",
             pairs_sent, pairs_kept, variates_seen);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
